FILE: sv/vcdf_pkg.sv
// Shared types, constants and tables of the voxel cone density filter.
package vcdf_pkg;

    // Default parameter values.
    localparam int MAX_DIM_DEF    = 32;
    localparam int MAX_RADIUS_DEF = 4;

    // Fixed field widths.
    localparam int COORD_W    = 5;
    localparam int DENS_W     = 16;
    localparam int SIZE_W     = 6;
    localparam int RAD_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Reset values of the configuration registers.
    localparam int SIZE_RESET   = 32;
    localparam int RADIUS_RESET = 384;

    // The square root table covers every squared distance that can fall inside the radius.
    localparam int SQRT_N   = 64;
    localparam int SQ_IDX_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X,
        CFG_SIZE_Y,
        CFG_SIZE_Z,
        CFG_RADIUS
    } cfg_idx_t;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CMD_STORE,
        CMD_QUERY,
        CMD_ERROR
    } cmd_kind_t;

    typedef enum logic {
        ERR_OK    = 1'b0,
        ERR_RANGE = 1'b1
    } err_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        cmd_kind_t           kind;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [DENS_W-1:0]   density;
    } cmd_t;

    // Current configuration, already clamped.
    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
        logic [RAD_W-1:0]  radius;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_WAIT,
        ST_RESULT
    } back_state_t;

    typedef logic [RAD_W-1:0] sqrt_tab_t [SQRT_N];

    // round(256 * sqrt(n)) for each table entry, built at elaboration.
    function automatic sqrt_tab_t build_sqrt_tab();
        sqrt_tab_t tab;
        int        target;
        int        s;
        int        t;
        for (int n = 0; n < SQRT_N; n++) begin
            target = n << 16;
            s      = 0;
            for (int b = 11; b >= 0; b--) begin
                t = s | (1 << b);
                if (t * t <= target) begin
                    s = t;
                end
            end
            if (s * s + s < target) begin
                s = s + 1;
            end
            tab[n] = RAD_W'(s);
        end
        return tab;
    endfunction

    localparam sqrt_tab_t SQRT_TAB = build_sqrt_tab();

endpackage

FILE: sv/vcdf_if.sv
// Handshake interfaces for the item, result and configuration channels.
interface vcdf_item_if
    import vcdf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               op;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [DENS_W-1:0]  density_in;

    modport source (output valid, op, coord_x, coord_y, coord_z, density_in, input ready);
    modport sink   (input valid, op, coord_x, coord_y, coord_z, density_in, output ready);
endinterface

interface vcdf_result_if
    import vcdf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DENS_W-1:0] filtered_density;
    logic              error_code;

    modport source (output valid, filtered_density, error_code, input ready);
    modport sink   (input valid, filtered_density, error_code, output ready);
endinterface

interface vcdf_cfg_if
    import vcdf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/vcdf_front.sv
// Front end: configuration registers, item acceptance and range classification.
module vcdf_front
    import vcdf_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    vcdf_item_if.sink   item,
    vcdf_cfg_if.sink    cfg,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd,
    output cfg_t        cfg_out
);

    localparam int RAD_LIM = MAX_RADIUS * 256;

    logic [SIZE_W-1:0] size_x_reg, size_x_next;
    logic [SIZE_W-1:0] size_y_reg, size_y_next;
    logic [SIZE_W-1:0] size_z_reg, size_z_next;
    logic [RAD_W-1:0]  radius_reg, radius_next;
    logic [SIZE_W-1:0] size_clamped;
    logic [RAD_W-1:0]  radius_clamped;
    logic              out_of_range;

    // Clamp the written value into the legal range of each register.
    always_comb
    begin
        size_clamped = SIZE_W'(cfg.data);
        if (size_clamped == '0) begin
            size_clamped = SIZE_W'(1);
        end else if (32'(size_clamped) > MAX_DIM) begin
            size_clamped = SIZE_W'(MAX_DIM);
        end
        radius_clamped = RAD_W'(cfg.data);
        if (32'(radius_clamped) > RAD_LIM) begin
            radius_clamped = RAD_W'(RAD_LIM);
        end
    end

    // Register write decode.
    always_comb
    begin
        size_x_next = size_x_reg;
        size_y_next = size_y_reg;
        size_z_next = size_z_reg;
        radius_next = radius_reg;
        if (cfg.valid) begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_SIZE_X: size_x_next = size_clamped;
                CFG_SIZE_Y: size_y_next = size_clamped;
                CFG_SIZE_Z: size_z_next = size_clamped;
                CFG_RADIUS: radius_next = radius_clamped;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            size_x_reg <= SIZE_W'(SIZE_RESET);
            size_y_reg <= SIZE_W'(SIZE_RESET);
            size_z_reg <= SIZE_W'(SIZE_RESET);
            radius_reg <= RAD_W'(RADIUS_RESET);
        end else begin
            size_x_reg <= size_x_next;
            size_y_reg <= size_y_next;
            size_z_reg <= size_z_next;
            radius_reg <= radius_next;
        end
    end

    assign cfg.ready = 1'b1;
    assign cfg_out   = '{size_x: size_x_reg, size_y: size_y_reg,
                         size_z: size_z_reg, radius: radius_reg};

    // Classify each accepted beat and hand it to the queue.
    assign out_of_range = (SIZE_W'(item.coord_x) >= size_x_reg) ||
                          (SIZE_W'(item.coord_y) >= size_y_reg) ||
                          (SIZE_W'(item.coord_z) >= size_z_reg);

    assign item.ready = !q_full;
    assign q_push     = item.valid && !q_full;

    always_comb
    begin
        q_cmd.x       = item.coord_x;
        q_cmd.y       = item.coord_y;
        q_cmd.z       = item.coord_z;
        q_cmd.density = item.density_in;
        priority if (out_of_range) begin
            q_cmd.kind = CMD_ERROR;
        end else if (op_t'(item.op) == OP_STORE) begin
            q_cmd.kind = CMD_STORE;
        end else begin
            q_cmd.kind = CMD_QUERY;
        end
    end

endmodule

FILE: sv/vcdf_queue.sv
// Two-entry command queue between the front and the back.
module vcdf_queue
    import vcdf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);

endmodule

FILE: sv/vcdf_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 16 bits.
module vcdf_div
    import vcdf_pkg::*;
#(
    parameter int NUM_W = 37,
    parameter int DEN_W = 21
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [DENS_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;

    // One restoring step per cycle.
    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, q_reg[NUM_W-1]};
        if (start) begin
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(shifted - {1'b0, den_reg});
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = DEN_W'(shifted);
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = (q_reg > NUM_W'(16'hFFFF)) ? 16'hFFFF : DENS_W'(q_reg);

endmodule

FILE: sv/vcdf_back.sv
// Back end: voxel memory, neighborhood scan, accumulation and result register.
module vcdf_back
    import vcdf_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg_in,
    input  cmd_t          q_head,
    input  logic          q_empty,
    output logic          q_pop,
    vcdf_result_if.source result
);

    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 3 * DIM_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int RI_W   = $clog2(MAX_RADIUS + 1);
    localparam int OFS_W  = RI_W + 1;
    localparam int NC_W   = ((DIM_W > SIZE_W) ? DIM_W : SIZE_W) + 2;
    localparam int D2_W   = $clog2(3 * MAX_RADIUS * MAX_RADIUS + 1);
    localparam int R2_W   = 2 * RAD_W;
    localparam int CMP_W  = ((D2_W + 16) > R2_W) ? (D2_W + 16) : R2_W;
    localparam int NPTS   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W  = $clog2(NPTS + 1);
    localparam int PROD_W = RAD_W + DENS_W;
    localparam int ACC_W  = PROD_W + CNT_W;
    localparam int WS_W   = RAD_W + CNT_W;

    back_state_t              state_reg, state_next;
    cmd_t                     cur_reg, cur_next;
    logic signed [OFS_W-1:0]  ox_reg, ox_next;
    logic signed [OFS_W-1:0]  oy_reg, oy_next;
    logic signed [OFS_W-1:0]  oz_reg, oz_next;
    logic [RI_W-1:0]          rint_reg, rint_next;
    logic [R2_W-1:0]          r2_reg, r2_next;
    logic [1:0]               drain_reg, drain_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DENS_W-1:0]        out_d_reg, out_d_next;
    logic                     out_e_reg, out_e_next;
    logic [DENS_W-1:0]        res_d_reg, res_d_next;
    logic                     res_e_reg, res_e_next;

    // Scan pipeline and accumulators.
    logic [RAD_W-1:0]         s1_w_reg, s1_w_next;
    logic                     s1_center_reg, s1_center_next;
    logic [RAD_W-1:0]         s2_w_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [DENS_W-1:0]        center_reg;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [WS_W-1:0]          wsum_reg, wsum_next;

    // Voxel memory.
    logic [DENS_W-1:0]        mem [DEPTH];
    logic [DENS_W-1:0]        rd_reg;
    logic [ADDR_W-1:0]        mem_addr;
    logic                     mem_we;

    logic [RI_W-1:0]          rint_cfg;
    logic signed [OFS_W-1:0]  rint_s;
    logic signed [NC_W-1:0]   nx, ny, nz;
    logic signed [D2_W:0]     oxe, oye, oze;
    logic [D2_W-1:0]          d2;
    logic                     in_vol;
    logic                     in_rad;
    logic                     last_pt;
    logic                     div_start;
    logic                     div_done;
    logic [DENS_W-1:0]        div_quot;

    assign rint_cfg = RI_W'(({1'b0, cfg_in.radius} + 12'd255) >> 8);
    assign rint_s   = signed'(OFS_W'(rint_reg));

    // Neighbor coordinates, squared distance and the two inclusion tests.
    always_comb
    begin
        nx     = signed'(NC_W'(cur_reg.x)) + NC_W'(ox_reg);
        ny     = signed'(NC_W'(cur_reg.y)) + NC_W'(oy_reg);
        nz     = signed'(NC_W'(cur_reg.z)) + NC_W'(oz_reg);
        oxe    = (D2_W + 1)'(ox_reg);
        oye    = (D2_W + 1)'(oy_reg);
        oze    = (D2_W + 1)'(oz_reg);
        d2     = D2_W'(oxe * oxe + oye * oye + oze * oze);
        in_vol = (nx >= 0) && (nx < signed'(NC_W'(cfg_in.size_x))) &&
                 (ny >= 0) && (ny < signed'(NC_W'(cfg_in.size_y))) &&
                 (nz >= 0) && (nz < signed'(NC_W'(cfg_in.size_z)));
        in_rad = CMP_W'({d2, 16'd0}) <= CMP_W'(r2_reg);
        last_pt = (ox_reg == rint_s) && (oy_reg == rint_s) && (oz_reg == rint_s);
    end

    // Sequencer: pops commands, walks the neighborhood and builds the result.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oz_next        = oz_reg;
        rint_next      = rint_reg;
        r2_next        = r2_reg;
        drain_next     = drain_reg;
        res_d_next     = res_d_reg;
        res_e_next     = res_e_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_d_next     = out_d_reg;
        out_e_next     = out_e_reg;
        acc_next       = acc_reg + ACC_W'(prod_reg);
        wsum_next      = wsum_reg + WS_W'(s2_w_reg);
        s1_w_next      = '0;
        s1_center_next = 1'b0;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        div_start      = 1'b0;
        mem_addr       = {nz[DIM_W-1:0], ny[DIM_W-1:0], nx[DIM_W-1:0]};
        unique case (state_reg)
            ST_IDLE: begin
                mem_addr = {DIM_W'(q_head.z), DIM_W'(q_head.y), DIM_W'(q_head.x)};
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    unique case (q_head.kind)
                        CMD_STORE: mem_we = 1'b1;
                        CMD_QUERY: state_next = ST_SETUP;
                        CMD_ERROR: begin
                            res_d_next = '0;
                            res_e_next = ERR_RANGE;
                            state_next = ST_RESULT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SETUP: begin
                rint_next  = rint_cfg;
                r2_next    = R2_W'(cfg_in.radius * cfg_in.radius);
                ox_next    = -signed'(OFS_W'(rint_cfg));
                oy_next    = -signed'(OFS_W'(rint_cfg));
                oz_next    = -signed'(OFS_W'(rint_cfg));
                acc_next   = '0;
                wsum_next  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                s1_center_next = (ox_reg == 0) && (oy_reg == 0) && (oz_reg == 0);
                if (in_vol && in_rad) begin
                    s1_w_next = cfg_in.radius - SQRT_TAB[SQ_IDX_W'(d2)];
                end
                if (ox_reg != rint_s) begin
                    ox_next = ox_reg + OFS_W'(1);
                end else begin
                    ox_next = -rint_s;
                    if (oy_reg != rint_s) begin
                        oy_next = oy_reg + OFS_W'(1);
                    end else begin
                        oy_next = -rint_s;
                        oz_next = oz_reg + OFS_W'(1);
                    end
                end
                if (last_pt) begin
                    drain_next = 2'd2;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg - 2'd1;
                if (drain_reg == 2'd0) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                res_e_next = ERR_OK;
                if (wsum_reg == '0) begin
                    res_d_next = center_reg;
                    state_next = ST_RESULT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (div_done) begin
                    res_d_next = div_quot;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!out_valid_reg || result.ready) begin
                    out_valid_next = 1'b1;
                    out_d_next     = res_d_reg;
                    out_e_next     = res_e_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            drain_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            drain_reg     <= drain_next;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        ox_reg        <= ox_next;
        oy_reg        <= oy_next;
        oz_reg        <= oz_next;
        rint_reg      <= rint_next;
        r2_reg        <= r2_next;
        res_d_reg     <= res_d_next;
        res_e_reg     <= res_e_next;
        out_d_reg     <= out_d_next;
        out_e_reg     <= out_e_next;
        s1_w_reg      <= s1_w_next;
        s1_center_reg <= s1_center_next;
        s2_w_reg      <= s1_w_reg;
        prod_reg      <= s1_w_reg * rd_reg;
        acc_reg       <= acc_next;
        wsum_reg      <= wsum_next;
        if (s1_center_reg) begin
            center_reg <= rd_reg;
        end
    end

    // Single-port voxel memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_addr] <= cur_next.density;
        end
        rd_reg <= mem[mem_addr];
    end

    vcdf_div #(
        .NUM_W (ACC_W),
        .DEN_W (WS_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_reg + ACC_W'(wsum_reg >> 1)),
        .den   (wsum_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign result.valid            = out_valid_reg;
    assign result.filtered_density = out_d_reg;
    assign result.error_code       = out_e_reg;

    // The divider only runs on a nonzero weight sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> (wsum_reg != '0))
        else $error("divider running with zero weight sum");

    // The x and z scan offsets stay inside the cube of the current radius.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((ox_reg <= rint_s) && (ox_reg >= -rint_s) &&
                                    (oz_reg <= rint_s) && (oz_reg >= -rint_s)))
        else $error("scan offset outside radius cube");

    // Accumulators start each query from zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETUP) |=> ((acc_reg == '0) && (wsum_reg == '0)))
        else $error("accumulators not cleared at query start");

endmodule

FILE: sv/voxel_cone_density_filter_core.sv
// Top level of the voxel cone density filter.
//
//   channel  dir  payload                                     beat when
//   item     in   op, coord_x, coord_y, coord_z, density_in   item.valid && item.ready
//   result   out  filtered_density, error_code                result.valid && result.ready
//   cfg      in   index, data                                 cfg.valid && cfg.ready
//
// A store is written to the voxel memory at its pop; a range error goes from the pop straight to the result.
// A query pops, sets up, scans the (2*ceil(radius)+1)^3 neighborhood with one voxel read per cycle from
// the single memory port, drains the scan pipeline, starts the divider on a nonzero weight sum and
// hands off the result; the divider steps once per accumulator bit, 37 at the default parameters.
// Reset sets the sizes to 32 and the radius to 1.5; the voxel memory is not cleared.
// A two-entry queue lets the item side keep going while the back end works or the
// result register waits; cfg is always ready.
module voxel_cone_density_filter_core
    import vcdf_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    vcdf_item_if.sink     item,
    vcdf_result_if.source result,
    vcdf_cfg_if.sink      cfg
);

    cfg_t cfg_cur;
    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    vcdf_front #(
        .MAX_DIM    (MAX_DIM),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (push),
        .q_cmd   (push_cmd),
        .cfg_out (cfg_cur)
    );

    vcdf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    vcdf_back #(
        .MAX_DIM    (MAX_DIM),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_in  (cfg_cur),
        .q_head  (head_cmd),
        .q_empty (q_empty),
        .q_pop   (pop),
        .result  (result)
    );

endmodule

FILE: tb/voxel_cone_density_filter_core_tb.sv
// Self-checking testbench of the voxel cone density filter core.
module voxel_cone_density_filter_core_tb;
    import vcdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 820;
    localparam int QUIET_TAIL   = 60;
    localparam int SETTLE       = 20;
    localparam int LONG_HOLD    = 400;
    localparam int VOL_DEPTH    = 32 * 32 * 32;

    // One row of stimulus: a register write or an item, with an optional typed result.
    typedef struct packed {
        logic                  is_cfg;
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] data;
        op_t                   op;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [COORD_W-1:0]    z;
        logic [DENS_W-1:0]     dens;
        logic                  known;
        logic [DENS_W-1:0]     k_dens;
        err_t                  k_err;
    } stim_row_t;

    typedef struct {
        logic [DENS_W-1:0] dens;
        err_t              err;
    } outcome_t;

    localparam int DIR_N = 23;
    localparam stim_row_t DIRECTED [DIR_N] = '{
        '{1'b1, CFG_RADIUS, 11'h000, OP_STORE, 5'd0,  5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, ERR_OK},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_STORE, 5'd31, 5'd31, 5'd31, 16'hFFFF, 1'b0, 16'h0000, ERR_OK},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_QUERY, 5'd31, 5'd31, 5'd31, 16'h0000, 1'b1, 16'hFFFF, ERR_OK},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_STORE, 5'd0,  5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, ERR_OK},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_QUERY, 5'd0,  5'd0,  5'd0,  16'hFFFF, 1'b1, 16'h0000, ERR_OK},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_STORE, 5'd10, 5'd21, 5'd10, 16'h5555, 1'b0, 16'h0000, ERR_OK},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_QUERY, 5'd10, 5'd21, 5'd10, 16'hAAAA, 1'b1, 16'h5555, ERR_OK},
        '{1'b1, CFG_RADIUS, 11'h0FF, OP_STORE, 5'd0,  5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, ERR_OK},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_QUERY, 5'd10, 5'd21, 5'd10, 16'h0000, 1'b0, 16'h0000, ERR_OK},
        '{1'b1, CFG_SIZE_X, 11'h7C0, OP_STORE, 5'd0,  5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, ERR_OK},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_STORE, 5'd1,  5'd0,  5'd0,  16'h1234, 1'b1, 16'h0000, ERR_RANGE},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_QUERY, 5'd31, 5'd0,  5'd0,  16'h0000, 1'b1, 16'h0000, ERR_RANGE},
        '{1'b1, CFG_SIZE_Y, 11'h001, OP_STORE, 5'd0,  5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, ERR_OK},
        '{1'b1, CFG_SIZE_Z, 11'h7C1, OP_STORE, 5'd0,  5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, ERR_OK},
        '{1'b1, CFG_RADIUS, 11'h7FF, OP_STORE, 5'd0,  5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, ERR_OK},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_QUERY, 5'd0,  5'd0,  5'd0,  16'h0000, 1'b1, 16'h0000, ERR_OK},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_STORE, 5'd0,  5'd0,  5'd0,  16'hFFFF, 1'b0, 16'h0000, ERR_OK},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_QUERY, 5'd0,  5'd0,  5'd0,  16'h0000, 1'b1, 16'hFFFF, ERR_OK},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_STORE, 5'd0,  5'd1,  5'd0,  16'hAAAA, 1'b1, 16'h0000, ERR_RANGE},
        '{1'b0, CFG_SIZE_X, 11'h000, OP_QUERY, 5'd0,  5'd0,  5'd31, 16'h0000, 1'b1, 16'h0000, ERR_RANGE},
        '{1'b1, CFG_SIZE_X, 11'h03F, OP_STORE, 5'd0,  5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, ERR_OK},
        '{1'b1, CFG_SIZE_Y, 11'h020, OP_STORE, 5'd0,  5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, ERR_OK},
        '{1'b1, CFG_SIZE_Z, 11'h020, OP_STORE, 5'd0,  5'd0,  5'd0,  16'h0000, 1'b0, 16'h0000, ERR_OK}
    };

    logic clk;
    logic rst_n;

    vcdf_item_if   item_if ();
    vcdf_result_if res_if ();
    vcdf_cfg_if    cfg_if ();

    voxel_cone_density_filter_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // Planned stimulus and the volume contents it will have written.
    stim_row_t stim_q[$];
    int        n_items;
    int        plan_sx, plan_sy, plan_sz, plan_rad;
    bit        plan_written [VOL_DEPTH];

    // Filter state mirrored from accepted beats.
    int                mir_sx, mir_sy, mir_sz, mir_rad;
    logic [DENS_W-1:0] mir_vol [VOL_DEPTH];

    stim_row_t sent_q[$];
    outcome_t  pending_q[$];
    int        fails;
    int        results_seen;
    bit        quiet;

    // Clock, 20 ns period.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int clamp_extent(logic [CFG_DATA_W-1:0] data);
        int v;
        v = int'(data[SIZE_W-1:0]);
        if (v < 1)
            return 1;
        if (v > 32)
            return 32;
        return v;
    endfunction

    function automatic int clamp_radius(logic [CFG_DATA_W-1:0] data);
        return (int'(data) > 1024) ? 1024 : int'(data);
    endfunction

    function automatic int vox_addr(int x, int y, int z);
        return (z * 32 + y) * 32 + x;
    endfunction

    // Rounded 256*sqrt(d2) by bitwise integer square root.
    function automatic longint unsigned dist_q8(int d2);
        longint unsigned n;
        longint unsigned s;
        longint unsigned t;
        n = longint'(d2) << 16;
        s = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = s | (64'd1 << b);
            if (t * t <= n)
                s = t;
        end
        if (s * s + s < n)
            s = s + 1;
        return s;
    endfunction

    // Append a row and track the extents and written voxels it leads to.
    function automatic void plan_row(stim_row_t row);
        stim_q.insert(stim_q.size(), row);
        if (row.is_cfg)
        begin
            case (row.idx)
                CFG_SIZE_X: plan_sx = clamp_extent(row.data);
                CFG_SIZE_Y: plan_sy = clamp_extent(row.data);
                CFG_SIZE_Z: plan_sz = clamp_extent(row.data);
                default:    plan_rad = clamp_radius(row.data);
            endcase
        end
        else
        begin
            n_items++;
            if (row.op == OP_STORE && row.x < plan_sx && row.y < plan_sy && row.z < plan_sz)
                plan_written[vox_addr(row.x, row.y, row.z)] = 1'b1;
        end
    endfunction

    function automatic void plan_item(op_t op, int x, int y, int z, logic [DENS_W-1:0] dens);
        stim_row_t row;
        row = '0;
        row.op = op;
        row.x = COORD_W'(x);
        row.y = COORD_W'(y);
        row.z = COORD_W'(z);
        row.dens = dens;
        plan_row(row);
    endfunction

    function automatic void plan_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        plan_row(row);
    endfunction

    function automatic logic [DENS_W-1:0] rand_density();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return DENS_W'($urandom);
        endcase
    endfunction

    // Store every voxel a query at (x,y,z) will read that is not yet written.
    function automatic void fill_neighborhood(int x, int y, int z);
        int reach;
        int nx, ny, nz;
        reach = (plan_rad + 255) >> 8;
        for (int dz = -reach; dz <= reach; dz++)
            for (int dy = -reach; dy <= reach; dy++)
                for (int dx = -reach; dx <= reach; dx++)
                begin
                    nx = x + dx;
                    ny = y + dy;
                    nz = z + dz;
                    if (nx < 0 || ny < 0 || nz < 0 || nx >= plan_sx || ny >= plan_sy
                        || nz >= plan_sz)
                        continue;
                    if ((longint'(dx * dx + dy * dy + dz * dz) << 16)
                        > longint'(plan_rad) * plan_rad)
                        continue;
                    if (!plan_written[vox_addr(nx, ny, nz)])
                        plan_item(OP_STORE, nx, ny, nz, rand_density());
                end
    endfunction

    // Coordinate near an edge on a large extent, anywhere on a small one.
    function automatic int pick_coord(int extent);
        if (extent <= 8)
            return $urandom_range(0, extent - 1);
        return $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(extent - 3, extent - 1);
    endfunction

    // Size register value whose low bits give the extent; the upper bits are noise.
    function automatic logic [CFG_DATA_W-1:0] extent_data(int extent);
        logic [SIZE_W-1:0] low;
        low = SIZE_W'(extent);
        if (extent == 1 && $urandom_range(0, 3) == 0)
            low = '0;
        else if (extent == 32 && $urandom_range(0, 1) == 0)
            low = SIZE_W'($urandom_range(33, 63));
        return {5'($urandom), low};
    endfunction

    function automatic void plan_random_phase();
        bit                    full;
        logic [CFG_DATA_W-1:0] rad_data;
        int                    x, y, z;
        int                    count;
        full = ($urandom_range(0, 9) == 0);
        plan_cfg(CFG_SIZE_X, extent_data(full ? 32 : $urandom_range(1, 6)));
        plan_cfg(CFG_SIZE_Y, extent_data(full ? 32 : $urandom_range(1, 6)));
        plan_cfg(CFG_SIZE_Z, extent_data(($urandom_range(0, 5) == 0 || full) ? 32
                                         : $urandom_range(1, 6)));
        if (full || plan_sz > 8)
            rad_data = CFG_DATA_W'($urandom_range(0, 512));
        else if ($urandom_range(0, 7) == 0)
            rad_data = CFG_DATA_W'($urandom_range(1025, 2047));
        else if ($urandom_range(0, 7) == 0)
            rad_data = $urandom_range(0, 1) ? CFG_DATA_W'(0) : CFG_DATA_W'(1024);
        else
            rad_data = CFG_DATA_W'($urandom_range(0, 1024));
        plan_cfg(CFG_RADIUS, rad_data);

        count = $urandom_range(40, 90);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                // Noise: any coordinate; in range it is a store or a prepared query.
                x = $urandom_range(0, 31);
                y = $urandom_range(0, 31);
                z = $urandom_range(0, 31);
                if (full)
                    plan_item(OP_STORE, x, y, z, rand_density());
                else if (x < plan_sx && y < plan_sy && z < plan_sz)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        fill_neighborhood(x, y, z);
                        plan_item(OP_QUERY, x, y, z, DENS_W'($urandom));
                    end
                    else
                        plan_item(OP_STORE, x, y, z, rand_density());
                end
                else
                    plan_item(op_t'($urandom_range(0, 1)), x, y, z, rand_density());
            end
            else
            begin
                x = pick_coord(plan_sx);
                y = pick_coord(plan_sy);
                z = pick_coord(plan_sz);
                if ($urandom_range(0, 99) < 65)
                begin
                    fill_neighborhood(x, y, z);
                    plan_item(OP_QUERY, x, y, z, DENS_W'($urandom));
                end
                else
                    plan_item(OP_STORE, x, y, z, rand_density());
            end
        end
    endfunction

    // Expected outcome of one accepted item; returns 0 when it yields no result.
    function automatic bit filter_outcome(stim_row_t row, output outcome_t res);
        int              reach;
        int              nx, ny, nz, d2;
        longint unsigned wsum, acc, w, q;
        res.dens = '0;
        res.err  = ERR_OK;
        if (row.x >= mir_sx || row.y >= mir_sy || row.z >= mir_sz)
        begin
            res.err = ERR_RANGE;
            return 1'b1;
        end
        if (row.op == OP_STORE)
        begin
            mir_vol[vox_addr(row.x, row.y, row.z)] = row.dens;
            return 1'b0;
        end
        reach = (mir_rad + 255) >> 8;
        wsum  = 0;
        acc   = 0;
        for (int dz = -reach; dz <= reach; dz++)
            for (int dy = -reach; dy <= reach; dy++)
                for (int dx = -reach; dx <= reach; dx++)
                begin
                    nx = int'(row.x) + dx;
                    ny = int'(row.y) + dy;
                    nz = int'(row.z) + dz;
                    if (nx < 0 || ny < 0 || nz < 0 || nx >= mir_sx || ny >= mir_sy
                        || nz >= mir_sz)
                        continue;
                    d2 = dx * dx + dy * dy + dz * dz;
                    if ((longint'(d2) << 16) > longint'(mir_rad) * mir_rad)
                        continue;
                    w    = longint'(mir_rad) - dist_q8(d2);
                    wsum += w;
                    acc  += w * mir_vol[vox_addr(nx, ny, nz)];
                end
        if (wsum == 0)
            res.dens = mir_vol[vox_addr(row.x, row.y, row.z)];
        else
        begin
            q = (acc + wsum / 2) / wsum;
            res.dens = (q > 64'hFFFF) ? 16'hFFFF : DENS_W'(q);
        end
        return 1'b1;
    endfunction

    // Mirror register writes and predict each accepted item.
    always @(posedge clk)
    begin
        stim_row_t row;
        outcome_t  res;
        if (rst_n && cfg_if.valid && cfg_if.ready)
        begin
            case (cfg_idx_t'(cfg_if.index))
                CFG_SIZE_X: mir_sx = clamp_extent(cfg_if.data);
                CFG_SIZE_Y: mir_sy = clamp_extent(cfg_if.data);
                CFG_SIZE_Z: mir_sz = clamp_extent(cfg_if.data);
                default:    mir_rad = clamp_radius(cfg_if.data);
            endcase
        end
        if (rst_n && item_if.valid && item_if.ready)
        begin
            row = sent_q.pop_front();
            if (filter_outcome(row, res))
            begin
                if (row.known)
                begin
                    res.dens = row.k_dens;
                    res.err  = row.k_err;
                end
                pending_q.insert(pending_q.size(), res);
            end
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t exp_res;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (pending_q.size() == 0)
            begin
                $error("result beat with nothing expected: density %h error %0d",
                       res_if.filtered_density, res_if.error_code);
                fails++;
            end
            else
            begin
                exp_res = pending_q.pop_front();
                if (res_if.filtered_density !== exp_res.dens)
                begin
                    $error("filtered_density: expected %h, actual %h",
                           exp_res.dens, res_if.filtered_density);
                    fails++;
                end
                if (res_if.error_code !== exp_res.err)
                begin
                    $error("error_code: expected %0d, actual %0d",
                           exp_res.err, res_if.error_code);
                    fails++;
                end
            end
        end
    end

    // Result side: random stall bursts and one long hold-off that fills the block.
    initial
    begin
        bit held;
        int gap;
        held = 1'b0;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 40)
            begin
                held = 1'b1;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 6);
                res_if.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // Run limit.
    initial
    begin
        #150ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Reset, plan the stimulus, then drive it.
    initial
    begin
        stim_row_t row;
        int        gap;
        rst_n              = 1'b0;
        item_if.valid      = 1'b0;
        item_if.op         = OP_STORE;
        item_if.coord_x    = '0;
        item_if.coord_y    = '0;
        item_if.coord_z    = '0;
        item_if.density_in = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        fails              = 0;
        results_seen       = 0;
        quiet              = 1'b0;
        n_items            = 0;
        plan_sx  = SIZE_RESET;
        plan_sy  = SIZE_RESET;
        plan_sz  = SIZE_RESET;
        plan_rad = RADIUS_RESET;
        mir_sx   = SIZE_RESET;
        mir_sy   = SIZE_RESET;
        mir_sz   = SIZE_RESET;
        mir_rad  = RADIUS_RESET;

        for (int i = 0; i < DIR_N; i++)
            plan_row(DIRECTED[i]);
        n_items = 0;
        while (n_items < RANDOM_ITEMS)
            plan_random_phase();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < stim_q.size(); i++)
        begin
            row   = stim_q[i];
            quiet = (i >= stim_q.size() - QUIET_TAIL);
            if (row.is_cfg)
            begin
                // Registers change only with the block drained and settled.
                @(negedge clk);
                item_if.valid <= 1'b0;
                while (pending_q.size() != 0) @(posedge clk);
                repeat (SETTLE) @(posedge clk);
                @(negedge clk);
                cfg_if.valid <= 1'b1;
                cfg_if.index <= row.idx;
                cfg_if.data  <= row.data;
                do @(posedge clk); while (!cfg_if.ready);
                @(negedge clk);
                cfg_if.valid <= 1'b0;
            end
            else
            begin
                gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
                if (gap > 0)
                begin
                    @(negedge clk);
                    item_if.valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                @(negedge clk);
                sent_q.insert(sent_q.size(), row);
                item_if.valid      <= 1'b1;
                item_if.op         <= row.op;
                item_if.coord_x    <= row.x;
                item_if.coord_y    <= row.y;
                item_if.coord_z    <= row.z;
                item_if.density_in <= row.dens;
                do @(posedge clk); while (!item_if.ready);
            end
        end

        @(negedge clk);
        item_if.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/vcdf_pkg.sv
sv/vcdf_if.sv
sv/vcdf_front.sv
sv/vcdf_queue.sv
sv/vcdf_div.sv
sv/vcdf_back.sv
sv/voxel_cone_density_filter_core.sv
tb/voxel_cone_density_filter_core_tb.sv
